@@ hw/rtl/mtk_pkg.sv @@
// Shared types, character constants and the Morse code table of the text keyer.
// No dependencies; every other file of the keyer imports this package.
package mtk_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIT_W      = 11;
  localparam int DUR_W      = 14;
  localparam int FREQ_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int MAX_SYMS   = 7;
  localparam int LEN_W      = 3;
  localparam int SEQ_DEPTH  = 3;
  localparam int SEQ_IDX_W  = 2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B       = 8'h42;
  localparam logic [CHAR_W-1:0] CH_T       = 8'h54;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIT_MS  = 2'd0,
    REG_TONE_HZ = 2'd1
  } cfg_reg_t;

  // One looked-up character: symbols are left-aligned, first symbol in the
  // top bit, a one meaning a dash.
  typedef struct packed {
    logic                known;
    logic                space;
    logic [LEN_W-1:0]    len;
    logic [MAX_SYMS-1:0] pat;
  } morse_code_t;

  // Character handed from the text front end to the symbol shifter.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] code;
    logic              is_final;
  } char_req_t;

  // Durations of one, three and seven dits.
  typedef struct packed {
    logic [DUR_W-1:0] dit1;
    logic [DUR_W-1:0] dit3;
    logic [DUR_W-1:0] dit7;
  } dur_set_t;

  function automatic morse_code_t morse_lookup(input logic [CHAR_W-1:0] ch);
    morse_code_t         c;
    logic [MAX_SYMS-1:0] p;
    logic [LEN_W-1:0]    n;
    p = '0;
    n = '0;
    unique case (ch)
      8'h41: begin n = 3'd2; p = 7'b01;      end // A
      8'h42: begin n = 3'd4; p = 7'b1000;    end // B
      8'h43: begin n = 3'd4; p = 7'b1010;    end // C
      8'h44: begin n = 3'd3; p = 7'b100;     end // D
      8'h45: begin n = 3'd1; p = 7'b0;       end // E
      8'h46: begin n = 3'd4; p = 7'b0010;    end // F
      8'h47: begin n = 3'd3; p = 7'b110;     end // G
      8'h48: begin n = 3'd4; p = 7'b0000;    end // H
      8'h49: begin n = 3'd2; p = 7'b00;      end // I
      8'h4A: begin n = 3'd4; p = 7'b0111;    end // J
      8'h4B: begin n = 3'd3; p = 7'b101;     end // K
      8'h4C: begin n = 3'd4; p = 7'b0100;    end // L
      8'h4D: begin n = 3'd2; p = 7'b11;      end // M
      8'h4E: begin n = 3'd2; p = 7'b10;      end // N
      8'h4F: begin n = 3'd3; p = 7'b111;     end // O
      8'h50: begin n = 3'd4; p = 7'b0110;    end // P
      8'h51: begin n = 3'd4; p = 7'b1101;    end // Q
      8'h52: begin n = 3'd3; p = 7'b010;     end // R
      8'h53: begin n = 3'd3; p = 7'b000;     end // S
      8'h54: begin n = 3'd1; p = 7'b1;       end // T
      8'h55: begin n = 3'd3; p = 7'b001;     end // U
      8'h56: begin n = 3'd4; p = 7'b0001;    end // V
      8'h57: begin n = 3'd3; p = 7'b011;     end // W
      8'h58: begin n = 3'd4; p = 7'b1001;    end // X
      8'h59: begin n = 3'd4; p = 7'b1011;    end // Y
      8'h5A: begin n = 3'd4; p = 7'b1100;    end // Z
      8'h30: begin n = 3'd5; p = 7'b11111;   end // 0
      8'h31: begin n = 3'd5; p = 7'b01111;   end // 1
      8'h32: begin n = 3'd5; p = 7'b00111;   end // 2
      8'h33: begin n = 3'd5; p = 7'b00011;   end // 3
      8'h34: begin n = 3'd5; p = 7'b00001;   end // 4
      8'h35: begin n = 3'd5; p = 7'b00000;   end // 5
      8'h36: begin n = 3'd5; p = 7'b10000;   end // 6
      8'h37: begin n = 3'd5; p = 7'b11000;   end // 7
      8'h38: begin n = 3'd5; p = 7'b11100;   end // 8
      8'h39: begin n = 3'd5; p = 7'b11110;   end // 9
      8'h2D: begin n = 3'd6; p = 7'b100001;  end // hyphen
      8'h2F: begin n = 3'd5; p = 7'b10010;   end // slash
      8'h2E: begin n = 3'd6; p = 7'b010101;  end // full stop
      8'h24: begin n = 3'd7; p = 7'b0001001; end // dollar
      8'h3A: begin n = 3'd6; p = 7'b111000;  end // colon
      8'h3B: begin n = 3'd6; p = 7'b101010;  end // semicolon
      8'h26: begin n = 3'd5; p = 7'b01000;   end // ampersand
      8'h21: begin n = 3'd6; p = 7'b101011;  end // exclamation mark
      8'h3F: begin n = 3'd6; p = 7'b001100;  end // question mark
      8'h2C: begin n = 3'd6; p = 7'b110011;  end // comma
      8'h27: begin n = 3'd6; p = 7'b011110;  end // apostrophe
      8'h28: begin n = 3'd5; p = 7'b10110;   end // open bracket
      8'h29: begin n = 3'd6; p = 7'b101101;  end // close bracket
      8'h3D: begin n = 3'd5; p = 7'b10001;   end // equals
      8'h2B: begin n = 3'd5; p = 7'b01010;   end // plus
      8'h5F: begin n = 3'd6; p = 7'b001101;  end // underscore
      8'h22: begin n = 3'd6; p = 7'b010010;  end // double quote
      8'h40: begin n = 3'd6; p = 7'b011010;  end // at sign
      default: begin n = '0; p = '0; end
    endcase
    c.space = (ch == CH_SPACE);
    c.known = (n != '0) || c.space;
    c.len   = n;
    c.pat   = p << (LEN_W'(MAX_SYMS) - n);
    return c;
  endfunction

endpackage

@@ hw/rtl/mtk_text_front.sv @@
// Text front end: accepts bytes, tracks the pending newline and queues the
// characters to be keyed (prosign letters and the byte itself). Uses mtk_pkg.
module mtk_text_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mtk_pkg::CHAR_W-1:0] char_code,
  input  logic                      end_of_text,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      take,
  output mtk_pkg::char_req_t        ch
);
  import mtk_pkg::*;

  logic [CHAR_W-1:0]    slot [SEQ_DEPTH];
  logic [CHAR_W-1:0]    slot_next [SEQ_DEPTH];
  logic [SEQ_IDX_W-1:0] cnt;
  logic [SEQ_IDX_W-1:0] cnt_next;
  logic                 newline_pending;
  logic                 accept;
  logic                 is_nl;
  logic                 pre_bt;
  logic                 pre_aa;
  logic                 main_ok;
  morse_code_t          main_code;

  assign in_ready  = (cnt == '0);
  assign accept    = in_valid && in_ready;
  assign is_nl     = (char_code == CH_NEWLINE);
  assign main_code = morse_lookup(char_code);
  assign pre_bt    = is_nl && newline_pending;
  assign pre_aa    = (is_nl && !newline_pending && end_of_text) || (!is_nl && newline_pending);
  // Unknown bytes are never queued, so the last queued character carries the
  // final keying item of the request.
  assign main_ok   = !is_nl && main_code.known;

  always_comb begin
    for (int i = 0; i < SEQ_DEPTH; i++) begin
      slot_next[i] = char_code;
    end
    cnt_next = '0;
    if (pre_bt) begin
      slot_next[0] = CH_B;
      slot_next[1] = CH_T;
      cnt_next     = SEQ_IDX_W'(2);
    end else if (pre_aa) begin
      slot_next[0] = CH_A;
      slot_next[1] = CH_A;
      cnt_next     = SEQ_IDX_W'(2);
    end
    if (main_ok) begin
      slot_next[cnt_next] = char_code;
      cnt_next            = cnt_next + SEQ_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt             <= '0;
      newline_pending <= 1'b0;
    end else if (accept) begin
      cnt             <= cnt_next;
      newline_pending <= is_nl && !newline_pending && !end_of_text;
    end else if (take) begin
      cnt <= cnt - SEQ_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SEQ_DEPTH; i++) begin
        slot[i] <= slot_next[i];
      end
    end else if (take) begin
      for (int i = 0; i < SEQ_DEPTH - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign ch.valid    = (cnt != '0);
  assign ch.code     = slot[0];
  assign ch.is_final = (cnt == SEQ_IDX_W'(1));

endmodule

@@ hw/rtl/mtk_symbol_shifter.sv @@
// Symbol shifter: loads one character's code and shifts it out a symbol at a
// time as tone and gap items into the output register. Uses mtk_pkg.
module mtk_symbol_shifter (
  input  logic                       clk,
  input  logic                       rst,
  input  mtk_pkg::char_req_t         ch,
  output logic                       take,
  input  mtk_pkg::dur_set_t          dur,
  input  logic [mtk_pkg::FREQ_W-1:0] tone_hz,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       tone_on,
  output logic [mtk_pkg::DUR_W-1:0]  duration_ms,
  output logic [mtk_pkg::FREQ_W-1:0] tone_freq_hz,
  output logic                       last
);
  import mtk_pkg::*;

  logic                active;
  logic                space;
  logic                in_gap;
  logic                is_final;
  logic [MAX_SYMS-1:0] pat;
  logic [LEN_W-1:0]    remain;
  logic                emit;
  logic                last_sym;
  logic                item_tone;
  logic [DUR_W-1:0]    item_dur;
  logic                item_last;
  morse_code_t         code;

  assign code     = morse_lookup(ch.code);
  assign take     = ch.valid && !active;
  assign emit     = active && (!out_valid || out_ready);
  assign last_sym = (remain == LEN_W'(1));

  always_comb begin
    item_tone = 1'b0;
    item_dur  = dur.dit3;
    item_last = 1'b0;
    if (space) begin
      item_dur  = dur.dit7;
      item_last = is_final;
    end else if (!in_gap) begin
      item_tone = 1'b1;
      item_dur  = pat[MAX_SYMS-1] ? dur.dit3 : dur.dit1;
    end else begin
      item_last = is_final && last_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        active <= 1'b1;
      end else if (emit && (space || (in_gap && last_sym))) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      space    <= code.space;
      pat      <= code.pat;
      remain   <= code.len;
      in_gap   <= 1'b0;
      is_final <= ch.is_final;
    end else if (emit && !space) begin
      in_gap <= !in_gap;
      if (in_gap) begin
        pat    <= pat << 1;
        remain <= remain - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tone_on      <= item_tone;
      duration_ms  <= item_dur;
      tone_freq_hz <= item_tone ? tone_hz : '0;
      last         <= item_last;
    end
  end

endmodule

@@ hw/rtl/morse_text_keyer_core.sv @@
// Top level of the Morse text keyer: configuration registers, dit multiples,
// the text front end and the symbol shifter. Uses mtk_pkg and both submodules.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  text in  | in_valid / in_ready   | char_code, end_of_text
//  keying   | out_valid / out_ready | tone_on, duration_ms, tone_freq_hz, last
//  config   | cfg_we                | cfg_index, cfg_data
//
// A request is taken once the previous one's characters have all been handed
// to the shifter. Each queued character is first loaded into the shifter,
// which then emits one keying item a cycle from its output register while the
// keying side does not stall.
// Reset is synchronous and clears the pending newline; no clearing pass.
// A stall on the keying side holds the shifter and thus the text input.
module morse_text_keyer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mtk_pkg::CHAR_W-1:0]     char_code,
  input  logic                           end_of_text,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           tone_on,
  output logic [mtk_pkg::DUR_W-1:0]      duration_ms,
  output logic [mtk_pkg::FREQ_W-1:0]     tone_freq_hz,
  output logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           cfg_we,
  input  logic [mtk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtk_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtk_pkg::*;

  logic [DIT_W-1:0]  dit_ms;
  logic [FREQ_W-1:0] tone_hz;
  logic [DUR_W-1:0]  dit_ext;
  dur_set_t          dur;
  char_req_t         ch;
  logic              take;

  always_ff @(posedge clk) begin
    if (rst) begin
      dit_ms  <= DIT_W'(60);
      tone_hz <= FREQ_W'(800);
    end else if (cfg_we) begin
      if (cfg_index == REG_DIT_MS) begin
        dit_ms <= cfg_data[DIT_W-1:0];
      end else if (cfg_index == REG_TONE_HZ) begin
        tone_hz <= cfg_data[FREQ_W-1:0];
      end
    end
  end

  // Seven dits of the widest setting still fit in the duration field.
  assign dit_ext  = DUR_W'(dit_ms);
  assign dur.dit1 = dit_ext;
  assign dur.dit3 = dit_ext + (dit_ext << 1);
  assign dur.dit7 = (dit_ext << 3) - dit_ext;

  mtk_text_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .take        (take),
    .ch          (ch)
  );

  mtk_symbol_shifter u_shifter (
    .clk          (clk),
    .rst          (rst),
    .ch           (ch),
    .take         (take),
    .dur          (dur),
    .tone_hz      (tone_hz),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tone_on      (tone_on),
    .duration_ms  (duration_ms),
    .tone_freq_hz (tone_freq_hz),
    .last         (last)
  );

  a_silence_no_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tone_on |-> tone_freq_hz == '0)
    else $error("silence item carries a tone frequency");

  a_silence_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tone_on |-> duration_ms == dur.dit3 || duration_ms == dur.dit7)
    else $error("silence item is neither a gap nor a word space");

  a_tone_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_on |-> duration_ms == dur.dit1 || duration_ms == dur.dit3)
    else $error("tone item is neither a dot nor a dash");

  a_take_needs_request: assert property (@(posedge clk) disable iff (rst)
    take |-> ch.valid && !in_ready)
    else $error("shifter took a character from an empty queue");

endmodule
